@@ design/m3i_pkg.sv @@
// Shared constants for the 3x3 matrix inverse pipeline.
package m3i_pkg;

  // number of matrix elements per word
  localparam int unsigned NumElem = 9;

endpackage

@@ design/m3i_mul.sv @@
// Registered signed multiplier, one product per cycle while en_i is high.
module m3i_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);
  logic signed [AW+BW-1:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;
endmodule

@@ design/m3i_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, signed in/out, saturated.
module m3i_div #(
  parameter int unsigned NW = 64,  // numerator magnitude width
  parameter int unsigned DW = 64,  // divisor magnitude width
  parameter int unsigned OW = 32   // output width
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,   // magnitude
  input  logic [DW-1:0] den_i,   // magnitude, nonzero unless zero_i
  input  logic          neg_i,
  input  logic          zero_i,
  output logic [OW-1:0] q_o
);
  localparam int unsigned RW = DW + 1;

  logic [NW-1:0] n_q [1:NW];
  logic [RW-1:0] r_q [1:NW];
  logic [NW-1:0] q_q [1:NW];
  logic [DW-1:0] d_q [1:NW];
  logic          s_q [1:NW];
  logic          z_q [1:NW];
  logic [OW-1:0] out_q;

  // one quotient bit per stage, MSB first
  for (genvar g = 0; g < NW; g++) begin : g_bit
    logic [NW-1:0] n_s;
    logic [RW-1:0] r_s;
    logic [NW-1:0] q_s;
    logic [DW-1:0] d_s;
    logic          s_s, z_s;
    logic [RW-1:0] rs;
    logic [RW:0]   diff;
    // stage operands: ports for the first stage, previous registers after
    if (g == 0) begin : g_src
      assign n_s = num_i;
      assign r_s = '0;
      assign q_s = '0;
      assign d_s = den_i;
      assign s_s = neg_i;
      assign z_s = zero_i;
    end else begin : g_src
      assign n_s = n_q[g];
      assign r_s = r_q[g];
      assign q_s = q_q[g];
      assign d_s = d_q[g];
      assign s_s = s_q[g];
      assign z_s = z_q[g];
    end
    always_comb begin
      rs   = {r_s[RW-2:0], n_s[NW-1]};
      diff = {1'b0, rs} - {2'b0, d_s};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g+1] <= {n_s[NW-2:0], 1'b0};
        r_q[g+1] <= diff[RW] ? rs : diff[RW-1:0];
        q_q[g+1] <= {q_s[NW-2:0], ~diff[RW]};
        d_q[g+1] <= d_s;
        s_q[g+1] <= s_s;
        z_q[g+1] <= z_s;
      end
    end
  end

  // sign, saturation, singular zeroing
  logic          big_pos, big_neg;
  logic [NW-1:0] qm;
  logic [OW-1:0] res;
  always_comb begin
    qm      = q_q[NW];
    big_pos = (qm > NW'({1'b0, {(OW-1){1'b1}}}));
    big_neg = (qm > NW'({1'b1, {(OW-1){1'b0}}}));
    if (z_q[NW]) begin
      res = '0;
    end else if (!s_q[NW]) begin
      res = big_pos ? {1'b0, {(OW-1){1'b1}}} : qm[OW-1:0];
    end else begin
      res = big_neg ? {1'b1, {(OW-1){1'b0}}} : (~qm[OW-1:0] + OW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= res;
    end
  end

  assign q_o = out_q;
endmodule

@@ design/matrix3_inverse.sv @@
// Top level: pipelined 3x3 fixed-point matrix inverse by adjugate and division.
//
//  channel | valid   | ready   | word
//  in      | valid_i | ready_o | a_r1c1_i .. a_r3c3_i
//  out     | valid_o | ready_i | inv_r1c1_o .. inv_r3c3_o, singular_o
//
// One word enters per cycle while the output is not stalled. Pipeline depth is set by the
// bit-per-stage divider over the shifted cofactor width (plus products and determinant).
// The whole pipeline advances when the output register is empty or being taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset clears only valid bits; data registers hold whatever they had.
module matrix3_inverse #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  logic signed [ELEM_WIDTH-1:0] a_r1c1_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r1c2_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r1c3_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r2c1_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r2c2_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r2c3_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r3c1_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r3c2_i,
  input  logic signed [ELEM_WIDTH-1:0] a_r3c3_i,
  output logic valid_o,
  input  logic ready_i,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c1_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c2_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r1c3_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c1_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c2_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r2c3_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r3c1_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r3c2_o,
  output logic signed [ELEM_WIDTH-1:0] inv_r3c3_o,
  output logic singular_o
);
  import m3i_pkg::*;

  localparam int unsigned EW  = ELEM_WIDTH;
  localparam int unsigned PW  = 2 * EW;          // product
  localparam int unsigned CW  = 2 * EW + 1;      // cofactor
  localparam int unsigned HW  = CW - EW;         // upper cofactor slice
  localparam int unsigned DPW = 3 * EW + 1;      // det partial product
  localparam int unsigned DTW = 3 * EW + 3;      // determinant
  localparam int unsigned NW  = CW - 1 + 2 * FRAC_BITS + 1; // |cof|<<2F
  localparam int unsigned DMW = DTW;             // |det|
  localparam int unsigned Lat = 5 + NW + 1;      // input to output register

  // single enable: advance unless a full output word is stalled
  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // valid shift line
  logic [Lat-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], valid_i};
    end
  end
  assign valid_o = v_q[Lat-1];

  logic signed [EW-1:0] a [NumElem];
  assign a = '{a_r1c1_i, a_r1c2_i, a_r1c3_i, a_r2c1_i, a_r2c2_i,
               a_r2c3_i, a_r3c1_i, a_r3c2_i, a_r3c3_i};

  // cofactor index table: a[p]*a[q] - a[r]*a[s]
  localparam logic [3:0] CofIdx [NumElem][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // stage 1: products; stage 2: cofactors
  logic signed [PW-1:0] pa [NumElem];
  logic signed [PW-1:0] pb [NumElem];
  logic signed [CW-1:0] cof_q [NumElem];
  logic signed [EW-1:0] a1_q [3];
  logic signed [EW-1:0] a2_q [3];

  for (genvar k = 0; k < NumElem; k++) begin : g_cof
    m3i_mul #(.AW(EW), .BW(EW)) u_mul_a (
      .clk_i, .en_i(en), .a_i(a[CofIdx[k][0]]), .b_i(a[CofIdx[k][1]]), .p_o(pa[k]));
    m3i_mul #(.AW(EW), .BW(EW)) u_mul_b (
      .clk_i, .en_i(en), .a_i(a[CofIdx[k][2]]), .b_i(a[CofIdx[k][3]]), .p_o(pb[k]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        cof_q[k] <= CW'(pa[k]) - CW'(pb[k]);
      end
    end
  end

  // first-row elements delayed to line up with cofactors
  for (genvar j = 0; j < 3; j++) begin : g_row
    always_ff @(posedge clk_i) begin
      if (en) begin
        a1_q[j] <= a[j];
        a2_q[j] <= a1_q[j];
      end
    end
  end

  // stage 3: det partial products on the low and high cofactor slices
  // stage 4: slices recombined; stage 5: determinant sum
  logic signed [EW+HW-1:0] dlo [3];
  logic signed [EW+HW-1:0] dhi [3];
  logic signed [DPW-1:0]   dp_q [3];
  logic signed [CW-1:0]    cof3_q [NumElem];
  logic signed [CW-1:0]    cof4_q [NumElem];
  logic signed [CW-1:0]    cof5_q [NumElem];
  logic signed [DTW-1:0]   det_q;
  for (genvar j = 0; j < 3; j++) begin : g_det
    m3i_mul #(.AW(EW), .BW(HW)) u_mul_lo (
      .clk_i, .en_i(en), .a_i(a2_q[j]), .b_i({1'b0, cof_q[3*j][EW-1:0]}), .p_o(dlo[j]));
    m3i_mul #(.AW(EW), .BW(HW)) u_mul_hi (
      .clk_i, .en_i(en), .a_i(a2_q[j]), .b_i(cof_q[3*j][CW-1:EW]), .p_o(dhi[j]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        dp_q[j] <= (DPW'(dhi[j]) <<< EW) + DPW'(dlo[j]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      cof3_q <= cof_q;
      cof4_q <= cof3_q;
      cof5_q <= cof4_q;
      det_q  <= DTW'(dp_q[0]) + DTW'(dp_q[1]) + DTW'(dp_q[2]);
    end
  end

  // stage 6 onward: dividers on magnitudes
  logic          det_neg, det_zero;
  logic [DMW-1:0] det_mag;
  always_comb begin
    det_neg  = det_q[DTW-1];
    det_zero = (det_q == '0);
    det_mag  = det_neg ? DMW'(-det_q) : DMW'(det_q);
  end

  logic [EW-1:0] q [NumElem];
  for (genvar k = 0; k < NumElem; k++) begin : g_div
    logic           cneg;
    logic [NW-1:0]  cmag;
    always_comb begin
      cneg = cof5_q[k][CW-1];
      cmag = {(cneg ? (CW-1)'(-cof5_q[k]) : cof5_q[k][CW-2:0]),
              {(2*FRAC_BITS){1'b0}}, 1'b0} >> 1;
    end
    m3i_div #(.NW(NW), .DW(DMW), .OW(EW)) u_div (
      .clk_i, .en_i(en), .num_i(cmag), .den_i(det_mag),
      .neg_i(cneg ^ det_neg), .zero_i(det_zero), .q_o(q[k]));
  end

  // singular flag delay line matching divider
  logic [NW:0] sing_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q <= {sing_q[NW-1:0], det_zero};
    end
  end

  assign inv_r1c1_o = q[0];
  assign inv_r1c2_o = q[1];
  assign inv_r1c3_o = q[2];
  assign inv_r2c1_o = q[3];
  assign inv_r2c2_o = q[4];
  assign inv_r2c3_o = q[5];
  assign inv_r3c1_o = q[6];
  assign inv_r3c2_o = q[7];
  assign inv_r3c3_o = q[8];
  assign singular_o = sing_q[NW];

  // checks
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(inv_r1c1_o) && $stable(singular_o))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o == (!valid_o || ready_i))
    else $error("ready not tied to output space");
  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && singular_o |-> inv_r2c2_o == '0 && inv_r3c3_o == '0)
    else $error("singular word with nonzero element");
endmodule

@@ verif/matrix3_inverse_test.sv @@
// Self-checking testbench for the pipelined 3x3 fixed-point matrix inverse.
`timescale 1ns / 1ps

module matrix3_inverse_test;

  localparam int unsigned EW = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned ItemsPerPhase = 600;
  localparam int unsigned DrainCycles = 2 * EW + 2 * FB + 7 + 50;
  localparam int unsigned StallLimit = 20000;
  localparam logic [EW-1:0] One = 32'h0001_0000;
  localparam logic [EW-1:0] MaxPos = 32'h7fff_ffff;
  localparam logic [EW-1:0] MaxNeg = 32'h8000_0000;

  // element order: r1c1 r1c2 r1c3 r2c1 .. r3c3
  typedef logic [8:0][EW-1:0] matrix_t;
  typedef struct packed {
    matrix_t inv;
    logic    singular;
  } inverse_t;

  typedef logic signed [255:0] big_t;

  // cofactor terms per output position: a[p]*a[q] - a[r]*a[s]
  localparam int CofTerm [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  // exact adjugate / determinant with truncating division and saturation
  function automatic inverse_t invert_matrix(matrix_t m);
    big_t a [9];
    big_t cof [9];
    big_t det, num, quo;
    inverse_t r;
    for (int k = 0; k < 9; k++) a[k] = big_t'($signed(m[k]));
    for (int k = 0; k < 9; k++) begin
      cof[k] = a[CofTerm[k][0]] * a[CofTerm[k][1]] - a[CofTerm[k][2]] * a[CofTerm[k][3]];
    end
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) begin
      num = cof[k] <<< (2 * FB);
      quo = num / det;
      if (quo > big_t'($signed(MaxPos))) r.inv[k] = MaxPos;
      else if (quo < big_t'($signed(MaxNeg))) r.inv[k] = MaxNeg;
      else r.inv[k] = quo[EW-1:0];
    end
    return r;
  endfunction

  // holds expected inverses in acceptance order
  class inverse_scoreboard;
    inverse_t pending [$];
    int errors = 0;

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note(matrix_t m);
      pending.push_back(invert_matrix(m));
    endfunction

    task check(inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        report("result word with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.singular !== want.singular)
        report($sformatf("singular got %b want %b", got.singular, want.singular));
      for (int k = 0; k < 9; k++) begin
        if (got.inv[k] !== want.inv[k])
          report($sformatf("element %0d got %h want %h", k, got.inv[k], want.inv[k]));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  logic ready_o, valid_o, singular_o;
  matrix_t a_in = '0;
  matrix_t inv_out;
  inverse_scoreboard sb = new();
  int src_idle = 0;
  int sink_stall = 0;
  int quiet = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  matrix3_inverse uut (
    .clk_i, .rst_ni, .valid_i, .ready_o,
    .a_r1c1_i(a_in[0]), .a_r1c2_i(a_in[1]), .a_r1c3_i(a_in[2]),
    .a_r2c1_i(a_in[3]), .a_r2c2_i(a_in[4]), .a_r2c3_i(a_in[5]),
    .a_r3c1_i(a_in[6]), .a_r3c2_i(a_in[7]), .a_r3c3_i(a_in[8]),
    .valid_o, .ready_i,
    .inv_r1c1_o(inv_out[0]), .inv_r1c2_o(inv_out[1]), .inv_r1c3_o(inv_out[2]),
    .inv_r2c1_o(inv_out[3]), .inv_r2c2_o(inv_out[4]), .inv_r2c3_o(inv_out[5]),
    .inv_r3c1_o(inv_out[6]), .inv_r3c2_o(inv_out[7]), .inv_r3c3_o(inv_out[8]),
    .singular_o
  );

  // receiver back-pressure
  always @(posedge clk_i) begin
    ready_i <= ($urandom_range(99) >= sink_stall);
  end

  // result words checked mid-cycle, taken at the next rising edge
  always @(negedge clk_i) begin
    if (valid_o && ready_i) sb.check('{inv: inv_out, singular: singular_o});
  end

  // watchdog on cycles without any handshake
  always @(negedge clk_i) begin
    if ((valid_o && ready_i) || (valid_i && ready_o)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > StallLimit) begin
      $display("matrix3_inverse: mismatch");
      $finish;
    end
  end

  // called at a rising edge; returns at the edge that takes the word
  task automatic send_matrix(matrix_t m);
    while ($urandom_range(99) < src_idle) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    a_in <= m;
    do @(negedge clk_i); while (!ready_o);
    sb.note(m);
    @(posedge clk_i);
  endtask

  function automatic logic [EW-1:0] rand_word();
    return $urandom();
  endfunction

  // random matrix of a mixed flavor
  function automatic matrix_t rand_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 9; k++) begin
      case (kind)
        0, 1: m[k] = rand_word();
        2, 3: m[k] = EW'($signed($urandom_range(8 * One) - 4 * One));
        4: m[k] = EW'($signed($urandom_range(64) - 32));
        default: m[k] = EW'($signed($urandom_range(2 * One) - One));
      endcase
    end
    // well conditioned: push the diagonal away from zero (r3c3 downward)
    if (kind >= 5 && kind <= 8) begin
      m[0] = m[0] + 4 * One;
      m[4] = m[4] + 4 * One;
      m[8] = m[8] - 4 * One;
    end
    // third row from row one: each element copied or zeroed (singular if all copied or all zeroed)
    if (kind == 9 || $urandom_range(19) == 0) begin
      for (int c = 0; c < 3; c++) m[6 + c] = ($urandom_range(1) == 1) ? m[c] : '0;
    end
    return m;
  endfunction

  task automatic directed_matrices();
    matrix_t m;
    send_matrix({One, 32'h0, 32'h0, 32'h0, One, 32'h0, 32'h0, 32'h0, One});
    send_matrix('0);
    send_matrix({9{MaxPos}});
    send_matrix({9{MaxNeg}});
    send_matrix({MaxPos, 32'h0, 32'h0, 32'h0, MaxNeg, 32'h0, 32'h0, 32'h0, MaxPos});
    send_matrix({MaxNeg, 32'h0, 32'h0, 32'h0, MaxNeg, 32'h0, 32'h0, 32'h0, MaxNeg});
    // tiny determinant drives the quotient into saturation
    send_matrix({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
    send_matrix({32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1});
    send_matrix({2 * One, 32'h0, 32'h0, 32'h0, 2 * One, 32'h0, 32'h0, 32'h0, 2 * One});
    send_matrix({-One, 32'h0, 32'h0, 32'h0, One, 32'h0, 32'h0, 32'h0, One});
    // permutation
    send_matrix({32'h0, One, 32'h0, 32'h0, 32'h0, One, One, 32'h0, 32'h0});
    // repeated row
    send_matrix({One, 2 * One, 3 * One, One, 2 * One, 3 * One, 32'h5, 32'h7, 32'h9});
    // rank two with non-trivial rows
    send_matrix({One, 2 * One, 3 * One, 4 * One, 5 * One, 6 * One,
                 7 * One, 8 * One, 9 * One});
    send_matrix({MaxPos, MaxNeg, 32'h1, 32'hffff_ffff, MaxPos, MaxNeg,
                 32'h0, 32'h1, MaxPos});
    send_matrix({32'h5555_5555, 32'haaaa_aaaa, 32'h0, 32'h0, 32'h5555_5555,
                 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h0, 32'h5555_5555});
    for (int k = 0; k < 6; k++) begin
      for (int j = 0; j < 9; j++) m[j] = rand_word();
      send_matrix(m);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    src_idle = 7;
    sink_stall = 68;
    directed_matrices();
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        src_idle = 68;
        sink_stall = 7;
      end else if (phase == 2) begin
        src_idle = 0;
        sink_stall = 0;
      end
      for (int n = 0; n < ItemsPerPhase; n++) send_matrix(rand_matrix());
    end
    valid_i <= 1'b0;
    sink_stall = 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) $display("matrix3_inverse: match");
    else $display("matrix3_inverse: mismatch");
    $finish;
  end

endmodule

@@ matrix3_inverse.f @@
design/m3i_pkg.sv
design/m3i_mul.sv
design/m3i_div.sv
design/matrix3_inverse.sv
verif/matrix3_inverse_test.sv
